[sv/upnt_pkg.sv]
// ============================================================================
// upnt_pkg: shared types and constants for the UDP port NAT translator
// Table size, action codes, header constants, and the word that travels along
// the cell chain.
// ============================================================================
package upnt_pkg;

    localparam int NAT_ENTRIES = 64;

    localparam logic [15:0] ETHER_IPV4 = 16'd2048;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [15:0] PORT_FIRST = 16'd1;
    localparam logic [15:0] PORT_LAST  = 16'd65534;

    localparam logic [2:0] ACT_SEND_EXT     = 3'd0;
    localparam logic [2:0] ACT_SEND_INT     = 3'd1;
    localparam logic [2:0] ACT_IGNORED      = 3'd2;
    localparam logic [2:0] ACT_DROP_UNKNOWN = 3'd3;
    localparam logic [2:0] ACT_DROP_FULL    = 3'd4;

    typedef enum logic [1:0] {
        K_OUTBOUND,
        K_INBOUND,
        K_IGNORE
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    // Word handed from cell to cell. For outbound words key_port carries the
    // port to assign if an insert happens; for inbound words it is the
    // destination port to match.
    typedef struct packed {
        logic        vld;
        t_kind       kind;
        logic [31:0] addr;
        logic [15:0] sport;
        logic [47:0] mac;
        logic [15:0] key_port;
        logic        hit;
        logic        new_ent;
        logic [31:0] res_addr;
        logic [15:0] res_port;
        logic [47:0] res_mac;
    } t_tok;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] addr;
        logic [15:0] port;
        logic [47:0] mac;
        logic        new_mapping;
    } t_res;

endpackage

[sv/upnt_cell.sv]
// ============================================================================
// upnt_cell: one translation table entry
// Holds one mapping, checks the passing word against it, claims a free entry
// for a new outbound mapping, and registers the word for the next cell.
// ============================================================================
module upnt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  upnt_pkg::t_tok  i_tok,
    output upnt_pkg::t_tok  o_tok
);

    logic        r_valid;
    logic [31:0] r_addr;
    logic [15:0] r_sport;
    logic [47:0] r_mac;
    logic [15:0] r_mport;
    upnt_pkg::t_tok r_tok;
    upnt_pkg::t_tok n_tok;
    logic        n_wr;

    always_comb begin
        n_tok = i_tok;
        n_wr  = 1'b0;
        if (i_tok.vld && !i_tok.hit && !i_tok.new_ent) begin
            if (r_valid) begin
                unique case (i_tok.kind)
                    upnt_pkg::K_OUTBOUND: begin
                        if (r_addr == i_tok.addr && r_sport == i_tok.sport &&
                            r_mac == i_tok.mac) begin
                            n_tok.hit      = 1'b1;
                            n_tok.res_port = r_mport;
                        end
                    end
                    upnt_pkg::K_INBOUND: begin
                        if (r_mport == i_tok.key_port) begin
                            n_tok.hit      = 1'b1;
                            n_tok.res_addr = r_addr;
                            n_tok.res_port = r_sport;
                            n_tok.res_mac  = r_mac;
                        end
                    end
                    default: ;
                endcase
            end else if (i_tok.kind == upnt_pkg::K_OUTBOUND) begin
                // entries fill from the front, so every valid entry was checked
                n_wr           = 1'b1;
                n_tok.new_ent  = 1'b1;
                n_tok.res_port = i_tok.key_port;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_wr) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_addr  <= i_tok.addr;
            r_sport <= i_tok.sport;
            r_mac   <= i_tok.mac;
            r_mport <= i_tok.key_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

[sv/udp_port_nat_translator_top.sv]
// ============================================================================
// udp_port_nat_translator_top: UDP network address and port translator
// Maps internal address/port/MAC triples to external ports and back.
// ============================================================================
// One header word is handled at a time. An accepted word walks a chain of
// NAT_ENTRIES table cells, one cell per clock; its result is registered and then
// moves into the output register once that register is free or not stalled, and
// a new word is taken in the cycle after that. Entries fill from the lowest cell
// and are never removed.
module udp_port_nat_translator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_src_addr,
    input  logic [15:0] i_src_port,
    input  logic [47:0] i_src_mac,
    input  logic [15:0] i_dst_port,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_action,
    output logic [31:0] o_out_addr,
    output logic [15:0] o_out_port,
    output logic [47:0] o_out_mac,
    output logic        o_new_mapping
);

    logic [31:0]      r_ext_addr;
    logic [15:0]      r_next_port;
    upnt_pkg::t_state r_state;
    upnt_pkg::t_state n_state;
    upnt_pkg::t_res   r_res;
    upnt_pkg::t_res   n_res;
    upnt_pkg::t_res   r_out;
    logic             r_out_vld;
    logic             w_accept;
    logic             w_load_out;
    logic [15:0]      w_port;
    upnt_pkg::t_tok   w_head;
    upnt_pkg::t_tok   w_chain [upnt_pkg::NAT_ENTRIES + 1];
    upnt_pkg::t_tok   w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_addr <= '0;
        end else if (i_cfg_we) begin
            r_ext_addr <= i_cfg_data;
        end
    end

    // out-of-range counter restarts at the first port
    assign w_port = (r_next_port < upnt_pkg::PORT_FIRST ||
                     r_next_port > upnt_pkg::PORT_LAST) ? upnt_pkg::PORT_FIRST
                                                        : r_next_port;

    always_comb begin
        w_head          = '0;
        w_head.vld      = w_accept;
        w_head.addr     = i_src_addr;
        w_head.sport    = i_src_port;
        w_head.mac      = i_src_mac;
        w_head.key_port = i_cmd ? i_dst_port : w_port;
        if (i_ether_type != upnt_pkg::ETHER_IPV4 || i_ip_protocol != upnt_pkg::PROTO_UDP) begin
            w_head.kind = upnt_pkg::K_IGNORE;
        end else if (i_cmd) begin
            w_head.kind = upnt_pkg::K_INBOUND;
        end else begin
            w_head.kind = upnt_pkg::K_OUTBOUND;
        end
    end

    assign w_chain[0] = w_head;

    for (genvar g = 0; g < upnt_pkg::NAT_ENTRIES; g++) begin : g_cell
        upnt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_chain[g]),
            .o_tok   (w_chain[g + 1])
        );
    end

    assign w_end = w_chain[upnt_pkg::NAT_ENTRIES];

    always_comb begin
        n_res = '0;
        unique case (w_end.kind)
            upnt_pkg::K_IGNORE: begin
                n_res.action = upnt_pkg::ACT_IGNORED;
            end
            upnt_pkg::K_OUTBOUND: begin
                if (w_end.hit || w_end.new_ent) begin
                    n_res.action      = upnt_pkg::ACT_SEND_EXT;
                    n_res.addr        = r_ext_addr;
                    n_res.port        = w_end.res_port;
                    n_res.new_mapping = w_end.new_ent;
                end else begin
                    n_res.action = upnt_pkg::ACT_DROP_FULL;
                end
            end
            upnt_pkg::K_INBOUND: begin
                if (w_end.hit) begin
                    n_res.action = upnt_pkg::ACT_SEND_INT;
                    n_res.addr   = w_end.res_addr;
                    n_res.port   = w_end.res_port;
                    n_res.mac    = w_end.res_mac;
                end else begin
                    n_res.action = upnt_pkg::ACT_DROP_UNKNOWN;
                end
            end
            default: n_res.action = upnt_pkg::ACT_IGNORED;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            upnt_pkg::S_IDLE: if (i_valid) n_state = upnt_pkg::S_RUN;
            upnt_pkg::S_RUN:  if (w_end.vld) n_state = upnt_pkg::S_HOLD;
            upnt_pkg::S_HOLD: if (!r_out_vld || !i_stall) n_state = upnt_pkg::S_IDLE;
            default:          n_state = upnt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_stall    = (r_state != upnt_pkg::S_IDLE);
        w_accept   = (r_state == upnt_pkg::S_IDLE) && i_valid;
        w_load_out = (r_state == upnt_pkg::S_HOLD) && (!r_out_vld || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= upnt_pkg::S_IDLE;
            r_next_port <= upnt_pkg::PORT_FIRST;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_end.vld && w_end.new_ent) begin
                r_next_port <= w_end.res_port + 16'd1;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end.vld) begin
            r_res <= n_res;
        end
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_action      = r_out.action;
    assign o_out_addr    = r_out.addr;
    assign o_out_port    = r_out.port;
    assign o_out_mac     = r_out.mac;
    assign o_new_mapping = r_out.new_mapping;

endmodule
